### hw/rtl/hcs_pkg.sv
// Shared types, constants and helper functions of the Hutton cipher stream unit.
package hcs_pkg;

  localparam int LETTERS  = 26;
  localparam int LETTER_W = 5;
  localparam int CFG_W    = 60;
  localparam int IDX_W    = 2;
  localparam int PACKED_W = 2 * CFG_W + 2 * LETTER_W;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef letter_t [LETTERS-1:0] key_arr_t;
  typedef logic [IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_DECRYPT_MODE = 2'd0;
  localparam cfg_idx_t CFG_KEY_LOW      = 2'd1;
  localparam cfg_idx_t CFG_KEY_MID      = 2'd2;
  localparam cfg_idx_t CFG_KEY_HIGH     = 2'd3;

  localparam letter_t LAST_LETTER = letter_t'(LETTERS - 1);
  localparam letter_t SHIFT_BIAS  = letter_t'(2);

  // Reduce a raw five-bit code into 0..25.
  function automatic letter_t fold_letter(input letter_t v);
    fold_letter = (v > LAST_LETTER) ? letter_t'(v - letter_t'(LETTERS)) : v;
  endfunction

  // Addition mod 26 of two letters that are already in range.
  function automatic letter_t add_mod(input letter_t a, input letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_mod = (s >= (LETTER_W + 1)'(LETTERS)) ?
              letter_t'(s - (LETTER_W + 1)'(LETTERS)) : letter_t'(s);
  endfunction

  // Subtraction mod 26 of two letters that are already in range.
  function automatic letter_t sub_mod(input letter_t a, input letter_t b);
    sub_mod = (a >= b) ? letter_t'(a - b) : letter_t'(a + letter_t'(LETTERS) - b);
  endfunction

  // The plain alphabet, which is its own inverse.
  function automatic key_arr_t plain_key();
    key_arr_t k;
    for (int i = 0; i < LETTERS; i++) begin
      k[i] = letter_t'(i);
    end
    plain_key = k;
  endfunction

endpackage

### hw/rtl/hcs_in_if.sv
// Input channel of the Hutton cipher stream unit: one text letter per transaction.
interface hcs_in_if;
  logic             valid;
  logic             ready;
  logic             first;
  hcs_pkg::letter_t text_letter;
  hcs_pkg::letter_t password_letter;

  modport source (output valid, output first, output text_letter,
                  output password_letter, input ready);
  modport sink   (input valid, input first, input text_letter,
                  input password_letter, output ready);
endinterface

### hw/rtl/hcs_out_if.sv
// Output channel of the Hutton cipher stream unit: one result letter per transaction.
interface hcs_out_if;
  logic             valid;
  logic             ready;
  hcs_pkg::letter_t out_letter;

  modport source (output valid, output out_letter, input ready);
  modport sink   (input valid, input out_letter, output ready);
endinterface

### hw/rtl/hutton_cipher_stream_unit.sv
// Hutton cipher stream unit: keyed-alphabet stream cipher over the letters A..Z.
//
// The unit takes one text letter and one password letter per input transaction and
// returns one cipher (or recovered plain) letter per output transaction, coded A=0 to
// Z=25, at a sustained rate of one letter per clock cycle unless the output stalls.
// That rate is set by the combinational path through the key registers: a lookup of the
// text letter's position, an add or subtract mod 26, a lookup of the letter found there
// and the swap of both letters, all written back at the same edge. The result sits in
// an output register, so a new letter is taken whenever that register is empty or is
// being drained in the same cycle. Software writes decrypt_mode (index 0) and the
// initial keyed alphabet, five bits per position, in key_letters_low (index 1,
// positions 0 to 11), key_letters_mid (index 2, positions 12 to 23) and
// key_letters_high (index 3, positions 24 and 25), only while the unit is idle. The
// reload image, the keyed alphabet and its inverse, is prepared at the configuration
// write itself, so an item with first set may follow the write in the very next cycle;
// if the written letters are not a permutation of A..Z the plain alphabet is loaded
// instead. Letter codes 26 to 31 are reduced by 26, and letters processed before any
// reload use the plain alphabet that reset establishes.
module hutton_cipher_stream_unit (
  input  logic                        clk,
  input  logic                        rst,
  hcs_in_if.sink                      in_ch,
  hcs_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  hcs_pkg::cfg_idx_t           cfg_index,
  input  logic [hcs_pkg::CFG_W-1:0]   cfg_wdata
);

  // Configuration registers.
  logic                              decrypt_mode;
  logic [hcs_pkg::CFG_W-1:0]         key_letters_low;
  logic [hcs_pkg::CFG_W-1:0]         key_letters_mid;
  logic [2*hcs_pkg::LETTER_W-1:0]    key_letters_high;

  // Register values as they stand after the current write, if any.
  logic [hcs_pkg::CFG_W-1:0]         key_low_next;
  logic [hcs_pkg::CFG_W-1:0]         key_mid_next;
  logic [2*hcs_pkg::LETTER_W-1:0]    key_high_next;
  logic [hcs_pkg::PACKED_W-1:0]      key_packed;

  // Reload image: the keyed alphabet and its inverse, ready for the next first letter.
  hcs_pkg::key_arr_t                 img_table;
  hcs_pkg::key_arr_t                 img_position;
  hcs_pkg::key_arr_t                 img_table_next;
  hcs_pkg::key_arr_t                 img_position_next;
  hcs_pkg::key_arr_t                 raw_letters;
  logic [hcs_pkg::LETTERS-1:0]       seen;
  logic                              all_in_range;
  logic                              is_perm;

  // Live cipher state.
  hcs_pkg::key_arr_t                 key_table;
  hcs_pkg::key_arr_t                 key_position;
  hcs_pkg::key_arr_t                 key_table_next;
  hcs_pkg::key_arr_t                 key_position_next;
  hcs_pkg::key_arr_t                 tab_cur;
  hcs_pkg::key_arr_t                 pos_cur;

  // Per-letter datapath.
  hcs_pkg::letter_t                  text;
  hcs_pkg::letter_t                  pass;
  hcs_pkg::letter_t                  shift;
  hcs_pkg::letter_t                  from_pos;
  hcs_pkg::letter_t                  to_pos;
  hcs_pkg::letter_t                  res;

  // Output register.
  logic                              out_valid;
  hcs_pkg::letter_t                  out_letter;
  logic                              in_fire;

  assign out_ch.valid      = out_valid;
  assign out_ch.out_letter = out_letter;
  assign in_ch.ready       = !out_valid || out_ch.ready;
  assign in_fire           = in_ch.valid && in_ch.ready;

  // The reload image is built from the register contents including this cycle's write.
  always_comb begin
    key_low_next  = key_letters_low;
    key_mid_next  = key_letters_mid;
    key_high_next = key_letters_high;
    if (cfg_we) begin
      case (cfg_index)
        hcs_pkg::CFG_KEY_LOW:  key_low_next  = cfg_wdata;
        hcs_pkg::CFG_KEY_MID:  key_mid_next  = cfg_wdata;
        hcs_pkg::CFG_KEY_HIGH: key_high_next = cfg_wdata[2*hcs_pkg::LETTER_W-1:0];
        default: ;
      endcase
    end
    key_packed = {key_high_next, key_mid_next, key_low_next};
  end

  // Check the 26 letters for a permutation and build the table and its inverse.
  // All letters in range and every letter seen means no letter repeats.
  always_comb begin
    all_in_range = 1'b1;
    seen         = '0;
    for (int i = 0; i < hcs_pkg::LETTERS; i++) begin
      raw_letters[i] = key_packed[i*hcs_pkg::LETTER_W +: hcs_pkg::LETTER_W];
      if (raw_letters[i] > hcs_pkg::LAST_LETTER) begin
        all_in_range = 1'b0;
      end else begin
        seen[raw_letters[i]] = 1'b1;
      end
    end
    is_perm = all_in_range && (&seen);

    for (int v = 0; v < hcs_pkg::LETTERS; v++) begin
      img_position_next[v] = '0;
      for (int i = 0; i < hcs_pkg::LETTERS; i++) begin
        if (raw_letters[i] == hcs_pkg::letter_t'(v)) begin
          img_position_next[v] = img_position_next[v] | hcs_pkg::letter_t'(i);
        end
      end
    end

    img_table_next = raw_letters;
    if (!is_perm) begin
      img_table_next    = hcs_pkg::plain_key();
      img_position_next = hcs_pkg::plain_key();
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode     <= 1'b0;
      key_letters_low  <= '0;
      key_letters_mid  <= '0;
      key_letters_high <= '0;
      img_table        <= hcs_pkg::plain_key();
      img_position     <= hcs_pkg::plain_key();
    end else if (cfg_we) begin
      if (cfg_index == hcs_pkg::CFG_DECRYPT_MODE) begin
        decrypt_mode <= cfg_wdata[0];
      end
      key_letters_low  <= key_low_next;
      key_letters_mid  <= key_mid_next;
      key_letters_high <= key_high_next;
      img_table        <= img_table_next;
      img_position     <= img_position_next;
    end
  end

  // One letter: find its key position, move by the shift, read the letter there and
  // swap the two letters in both the table and its inverse.
  always_comb begin
    tab_cur  = in_ch.first ? img_table : key_table;
    pos_cur  = in_ch.first ? img_position : key_position;
    text     = hcs_pkg::fold_letter(in_ch.text_letter);
    pass     = hcs_pkg::fold_letter(in_ch.password_letter);
    shift    = hcs_pkg::add_mod(hcs_pkg::add_mod(pass, tab_cur[0]), hcs_pkg::SHIFT_BIAS);
    from_pos = pos_cur[text];
    to_pos   = decrypt_mode ? hcs_pkg::sub_mod(from_pos, shift)
                            : hcs_pkg::add_mod(from_pos, shift);
    res      = tab_cur[to_pos];

    key_table_next            = tab_cur;
    key_table_next[from_pos]  = res;
    key_table_next[to_pos]    = text;
    key_position_next         = pos_cur;
    key_position_next[res]    = from_pos;
    key_position_next[text]   = to_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_table    <= hcs_pkg::plain_key();
      key_position <= hcs_pkg::plain_key();
      out_valid    <= 1'b0;
    end else if (in_fire) begin
      key_table    <= key_table_next;
      key_position <= key_position_next;
      out_valid    <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_letter <= res;
    end
  end

  // A taken letter always leaves a result waiting in the next cycle.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted letter produced no result");

  // Spot check that the live position table inverts the live key table at position 0.
  a_key_inverse: assert property (@(posedge clk) disable iff (rst)
    key_position[key_table[0]] == '0)
    else $error("key position table is not the inverse of the key table");

  // The reload image passes the same spot check at position 0.
  a_image_inverse: assert property (@(posedge clk) disable iff (rst)
    img_position[img_table[0]] == '0)
    else $error("reload image inverse is inconsistent");

  // Every result is a letter of the alphabet.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_letter <= hcs_pkg::LAST_LETTER))
    else $error("result letter out of range");

endmodule
